>>> src/salcp_pkg.sv
package salcp_pkg;

  localparam int CHAR_W  = 7;
  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 12;
  localparam int START_W = 12;
  localparam int LCP_W   = 13;
  localparam int RANK_W  = 12;
  localparam int LEN_W   = 13;
  localparam int STAT_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 2'd0,
    FN_RANK   = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_POS    = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_Q_RD,
    S_Q_POS,
    S_Q_LCP,
    S_RESP,
    S_SENT,
    S_CLR,
    S_CNT0,
    S_CNT1,
    S_CNT2,
    S_CNT3,
    S_SUM0,
    S_SUM1,
    S_SC0,
    S_SC1,
    S_SC2,
    S_SC3,
    S_TAIL,
    S_SHF0,
    S_SHF1,
    S_RK0,
    S_RK1,
    S_CMP0,
    S_CMP1,
    S_CMP2,
    S_CMP3,
    S_CMP4,
    S_CMP5,
    S_NEXT,
    S_INV0,
    S_INV1,
    S_KA0,
    S_KA1,
    S_KA2,
    S_KA3,
    S_KA4,
    S_KA5,
    S_KA6,
    S_DONE
  } state_t;

endpackage

>>> src/salcp_req_if.sv
interface salcp_req_if
  import salcp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [CHAR_W-1:0]   char_code;
  logic [INDEX_W-1:0]  index;

  modport source(output valid, func, char_code, index, input ready);
  modport sink(input valid, func, char_code, index, output ready);
endinterface

>>> src/salcp_rsp_if.sv
interface salcp_rsp_if
  import salcp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [START_W-1:0]  suffix_start;
  logic [LCP_W-1:0]    lcp_prev;
  logic [RANK_W-1:0]   rank;
  logic [LEN_W-1:0]    text_length;
  logic [STAT_W-1:0]   status;

  modport source(output valid, suffix_start, lcp_prev, rank, text_length, status,
                 input ready);
  modport sink(input valid, suffix_start, lcp_prev, rank, text_length, status,
               output ready);
endinterface

>>> src/suffix_array_lcp_builder.sv
// Channel | Dir | Payload                                             | Beat taken when
// req     | in  | func, char_code, index                              | valid && ready
// rsp     | out | suffix_start, lcp_prev, rank, text_length, status   | valid && ready
//
// Append and clear beats are answered from the output register, which is loaded as the beat
// is taken. A query on a built text steps through table reads, a dependent lcp read for a
// position query, then the response load (held while the output register is busy); the next
// request beat can be taken once the response is loaded and the sequencer is back in idle.
// The first query after the text changes runs the build sequencer first: the character pass,
// then the doubling rounds (the passes walk the memories with one dependent read per cycle),
// at most ceil(log2(len)) rounds, then the inverse table and Kasai's walk over the text
// positions, extending each carried match length one character at a time.
// rst (synchronous) clears the text length, the built mark and the handshake state; the
// memories keep their contents. A stalled rsp holds its beat; req is taken again once the
// output register is free or drains in the same cycle.
module suffix_array_lcp_builder
  import salcp_pkg::*;
#(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 128
) (
  input  logic        clk,
  input  logic        rst,
  salcp_req_if.sink   req,
  salcp_rsp_if.source rsp
);

  localparam int N   = MAX_LEN + 1;
  localparam int AW  = $clog2(N);
  localparam int BD  = (N > ALPHABET) ? N : ALPHABET;
  localparam int BAW = $clog2(BD);
  localparam int DW  = $clog2(BD + 1);
  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int SW  = DW + 2;
  localparam int KW  = DW + 1;
  localparam int IW  = (CW > INDEX_W) ? CW : INDEX_W;

  // Storage: text, suffix order, two rank tables (swapped each round), buckets, lcp
  logic [CHAR_W-1:0] text_mem [N];
  logic [DW-1:0]     sa_mem   [N];
  logic [DW-1:0]     ra_mem   [N];
  logic [DW-1:0]     rb_mem   [N];
  logic [DW-1:0]     bk_mem   [BD];
  logic [DW-1:0]     lc_mem   [N];

  logic              t_we;
  logic [AW-1:0]     t_wa, t_ra;
  logic [CHAR_W-1:0] t_wd, t_rd;
  logic              sa_we;
  logic [AW-1:0]     sa_wa, sa_ra;
  logic [DW-1:0]     sa_wd, sa_rd;
  logic              bk_we;
  logic [BAW-1:0]    bk_wa, bk_ra;
  logic [DW-1:0]     bk_wd, bk_rd;
  logic              lc_we;
  logic [AW-1:0]     lc_wa, lc_ra;
  logic [DW-1:0]     lc_wd, lc_rd;
  logic              cur_we, nxt_we;
  logic [AW-1:0]     cur_wa, cur_ra, nxt_wa, nxt_ra;
  logic [DW-1:0]     cur_wd, nxt_wd, cur_rd, nxt_rd;
  logic              ra_we, rb_we;
  logic [AW-1:0]     ra_wa, ra_ra, rb_wa, rb_ra;
  logic [DW-1:0]     ra_wd, rb_wd, ra_rd, rb_rd;

  // Control and working registers
  state_t            state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic              built, built_next;
  logic              sel, sel_next;
  logic              first, first_next;
  logic [DW-1:0]     i, i_next;
  logic [DW-1:0]     used, used_next;
  logic [DW-1:0]     classes, classes_next;
  logic [SW-1:0]     step, step_next;
  logic [DW-1:0]     acc, acc_next;
  logic [DW-1:0]     xr, xr_next;
  logic [DW-1:0]     cr, cr_next;
  logic [DW-1:0]     prev, prev_next;
  logic [DW-1:0]     breg, breg_next;
  logic [DW-1:0]     cb, cb_next;
  logic [DW-1:0]     ca, ca_next;
  logic [DW-1:0]     cas, cas_next;
  logic [DW-1:0]     rreg, rreg_next;
  logic [DW-1:0]     jreg, jreg_next;
  logic [KW-1:0]     k, k_next;
  logic [CHAR_W-1:0] t1, t1_next;
  logic [FUNC_W-1:0] q_func, q_func_next;
  logic [INDEX_W-1:0] q_idx, q_idx_next;
  logic [START_W-1:0] res_start, res_start_next;
  logic [LCP_W-1:0]  res_lcp, res_lcp_next;
  logic [RANK_W-1:0] res_rank, res_rank_next;
  logic              out_valid, out_valid_next;
  logic [START_W-1:0] o_start, o_start_next;
  logic [LCP_W-1:0]  o_lcp, o_lcp_next;
  logic [RANK_W-1:0] o_rank, o_rank_next;
  logic [LEN_W-1:0]  o_len, o_len_next;
  logic [STAT_W-1:0] o_status, o_status_next;

  logic [DW-1:0]     len;
  logic              out_free;
  logic              accept;

  assign len      = DW'(cnt) + DW'(1);
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept   = req.valid && req.ready;

  assign rsp.valid        = out_valid;
  assign rsp.suffix_start = o_start;
  assign rsp.lcp_prev     = o_lcp;
  assign rsp.rank         = o_rank;
  assign rsp.text_length  = o_len;
  assign rsp.status       = o_status;

  // Memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (t_we) text_mem[t_wa] <= t_wd;
    t_rd <= text_mem[t_ra];
  end

  always_ff @(posedge clk) begin
    if (sa_we) sa_mem[sa_wa] <= sa_wd;
    sa_rd <= sa_mem[sa_ra];
  end

  always_ff @(posedge clk) begin
    if (ra_we) ra_mem[ra_wa] <= ra_wd;
    ra_rd <= ra_mem[ra_ra];
  end

  always_ff @(posedge clk) begin
    if (rb_we) rb_mem[rb_wa] <= rb_wd;
    rb_rd <= rb_mem[rb_ra];
  end

  always_ff @(posedge clk) begin
    if (bk_we) bk_mem[bk_wa] <= bk_wd;
    bk_rd <= bk_mem[bk_ra];
  end

  always_ff @(posedge clk) begin
    if (lc_we) lc_mem[lc_wa] <= lc_wd;
    lc_rd <= lc_mem[lc_ra];
  end

  // Route the current/next rank views onto the two physical tables
  always_comb begin
    ra_we  = sel ? nxt_we : cur_we;
    ra_wa  = sel ? nxt_wa : cur_wa;
    ra_wd  = sel ? nxt_wd : cur_wd;
    ra_ra  = sel ? nxt_ra : cur_ra;
    rb_we  = sel ? cur_we : nxt_we;
    rb_wa  = sel ? cur_wa : nxt_wa;
    rb_wd  = sel ? cur_wd : nxt_wd;
    rb_ra  = sel ? cur_ra : nxt_ra;
    cur_rd = sel ? rb_rd : ra_rd;
    nxt_rd = sel ? ra_rd : rb_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      built     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      built     <= built_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sel       <= sel_next;
    first     <= first_next;
    i         <= i_next;
    used      <= used_next;
    classes   <= classes_next;
    step      <= step_next;
    acc       <= acc_next;
    xr        <= xr_next;
    cr        <= cr_next;
    prev      <= prev_next;
    breg      <= breg_next;
    cb        <= cb_next;
    ca        <= ca_next;
    cas       <= cas_next;
    rreg      <= rreg_next;
    jreg      <= jreg_next;
    k         <= k_next;
    t1        <= t1_next;
    q_func    <= q_func_next;
    q_idx     <= q_idx_next;
    res_start <= res_start_next;
    res_lcp   <= res_lcp_next;
    res_rank  <= res_rank_next;
    o_start   <= o_start_next;
    o_lcp     <= o_lcp_next;
    o_rank    <= o_rank_next;
    o_len     <= o_len_next;
    o_status  <= o_status_next;
  end

  always_comb begin
    logic [SW-1:0] step2;
    logic [DW-1:0] x;
    logic [DW-1:0] c;
    logic [DW-1:0] sum;
    logic          same;
    logic [KW-1:0] kd;

    state_next     = state;
    cnt_next       = cnt;
    built_next     = built;
    sel_next       = sel;
    first_next     = first;
    i_next         = i;
    used_next      = used;
    classes_next   = classes;
    step_next      = step;
    acc_next       = acc;
    xr_next        = xr;
    cr_next        = cr;
    prev_next      = prev;
    breg_next      = breg;
    cb_next        = cb;
    ca_next        = ca;
    cas_next       = cas;
    rreg_next      = rreg;
    jreg_next      = jreg;
    k_next         = k;
    t1_next        = t1;
    q_func_next    = q_func;
    q_idx_next     = q_idx;
    res_start_next = res_start;
    res_lcp_next   = res_lcp;
    res_rank_next  = res_rank;
    out_valid_next = out_valid;
    o_start_next   = o_start;
    o_lcp_next     = o_lcp;
    o_rank_next    = o_rank;
    o_len_next     = o_len;
    o_status_next  = o_status;

    t_we  = 1'b0; t_wa  = '0; t_wd  = '0; t_ra  = '0;
    sa_we = 1'b0; sa_wa = '0; sa_wd = '0; sa_ra = '0;
    bk_we = 1'b0; bk_wa = '0; bk_wd = '0; bk_ra = '0;
    lc_we = 1'b0; lc_wa = '0; lc_wd = '0; lc_ra = '0;
    cur_we = 1'b0; cur_wa = '0; cur_wd = '0; cur_ra = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = '0;

    step2 = step << 1;
    x     = '0;
    c     = '0;
    sum   = '0;
    same  = 1'b0;
    kd    = '0;

    // Drop the beat once taken downstream
    if (out_valid && rsp.ready) out_valid_next = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          q_func_next    = req.func;
          q_idx_next     = req.index;
          o_start_next   = '0;
          o_lcp_next     = '0;
          o_rank_next    = '0;
          o_status_next  = STAT_OK;
          o_len_next     = LEN_W'(cnt);
          case (func_t'(req.func))
            FN_APPEND: begin
              out_valid_next = 1'b1;
              if (cnt == CW'(MAX_LEN)) begin
                o_status_next = STAT_FULL;
              end else if (req.char_code != '0 && int'(req.char_code) < ALPHABET) begin
                t_we       = 1'b1;
                t_wa       = AW'(cnt);
                t_wd       = req.char_code;
                cnt_next   = cnt + CW'(1);
                built_next = 1'b0;
                o_len_next = LEN_W'(cnt + CW'(1));
              end
            end
            FN_CLEAR: begin
              out_valid_next = 1'b1;
              cnt_next       = '0;
              built_next     = 1'b0;
              o_len_next     = '0;
            end
            default: begin
              if (IW'(req.index) >= IW'(cnt)) begin
                out_valid_next = 1'b1;
                o_status_next  = STAT_RANGE;
              end else if (built) begin
                state_next = S_Q_RD;
              end else begin
                state_next = S_SENT;
              end
            end
          endcase
        end
      end

      // Query on built tables
      S_Q_RD: begin
        sa_ra      = AW'(q_idx) + AW'(1);
        lc_ra      = AW'(q_idx) + AW'(1);
        cur_ra     = AW'(q_idx);
        state_next = S_Q_POS;
      end
      S_Q_POS: begin
        if (q_func == FN_RANK) begin
          res_start_next = START_W'(sa_rd);
          res_rank_next  = RANK_W'(q_idx);
          res_lcp_next   = LCP_W'(lc_rd);
          state_next     = S_RESP;
        end else begin
          res_start_next = START_W'(q_idx);
          res_rank_next  = RANK_W'(cur_rd - DW'(1));
          lc_ra          = AW'(cur_rd);
          state_next     = S_Q_LCP;
        end
      end
      S_Q_LCP: begin
        res_lcp_next = LCP_W'(lc_rd);
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          o_start_next   = res_start;
          o_lcp_next     = res_lcp;
          o_rank_next    = res_rank;
          o_len_next     = LEN_W'(cnt);
          o_status_next  = STAT_OK;
          state_next     = S_IDLE;
        end
      end

      // Build: sentinel, then the first counting sort on raw characters
      S_SENT: begin
        t_we         = 1'b1;
        t_wa         = AW'(cnt);
        t_wd         = '0;
        sel_next     = 1'b0;
        first_next   = 1'b1;
        classes_next = DW'(ALPHABET);
        i_next       = '0;
        state_next   = S_CLR;
      end
      S_CLR: begin
        bk_we = 1'b1;
        bk_wa = BAW'(i);
        bk_wd = '0;
        if (i == classes - DW'(1)) begin
          i_next     = '0;
          state_next = S_CNT0;
        end else begin
          i_next = i + DW'(1);
        end
      end
      S_CNT0: begin
        nxt_ra     = AW'(i);
        t_ra       = AW'(i);
        state_next = S_CNT1;
      end
      S_CNT1: begin
        x          = first ? i : nxt_rd;
        xr_next    = x;
        cur_ra     = AW'(x);
        t_ra       = AW'(i);
        state_next = S_CNT2;
      end
      S_CNT2: begin
        c = first ? DW'(t_rd) : cur_rd;
        if (first) begin
          cur_we = 1'b1;
          cur_wa = AW'(i);
          cur_wd = c;
        end
        bk_ra      = BAW'(c);
        cr_next    = c;
        state_next = S_CNT3;
      end
      S_CNT3: begin
        bk_we = 1'b1;
        bk_wa = BAW'(cr);
        bk_wd = bk_rd + DW'(1);
        if (i == len - DW'(1)) begin
          i_next     = '0;
          acc_next   = '0;
          state_next = S_SUM0;
        end else begin
          i_next     = i + DW'(1);
          state_next = S_CNT0;
        end
      end
      S_SUM0: begin
        bk_ra      = BAW'(i);
        state_next = S_SUM1;
      end
      S_SUM1: begin
        sum      = acc + bk_rd;
        bk_we    = 1'b1;
        bk_wa    = BAW'(i);
        bk_wd    = sum;
        acc_next = sum;
        if (i == classes - DW'(1)) begin
          i_next     = len - DW'(1);
          state_next = S_SC0;
        end else begin
          i_next     = i + DW'(1);
          state_next = S_SUM0;
        end
      end
      // Scatter from the top so equal keys keep their order
      S_SC0: begin
        nxt_ra     = AW'(i);
        state_next = S_SC1;
      end
      S_SC1: begin
        x          = first ? i : nxt_rd;
        xr_next    = x;
        cur_ra     = AW'(x);
        state_next = S_SC2;
      end
      S_SC2: begin
        bk_ra      = BAW'(cur_rd);
        cr_next    = cur_rd;
        state_next = S_SC3;
      end
      S_SC3: begin
        bk_we = 1'b1;
        bk_wa = BAW'(cr);
        bk_wd = bk_rd - DW'(1);
        sa_we = 1'b1;
        sa_wa = AW'(bk_rd - DW'(1));
        sa_wd = xr;
        if (i == '0) begin
          if (first) begin
            first_next = 1'b0;
            step_next  = SW'(1);
            used_next  = '0;
            i_next     = len - DW'(1);
            state_next = S_TAIL;
          end else begin
            sel_next   = !sel;
            state_next = S_RK0;
          end
        end else begin
          i_next     = i - DW'(1);
          state_next = S_SC0;
        end
      end

      // Second-key order: suffixes with no partner first, then shifted order
      S_TAIL: begin
        nxt_we    = 1'b1;
        nxt_wa    = AW'(used);
        nxt_wd    = i;
        used_next = used + DW'(1);
        if (i == len - DW'(1)) begin
          i_next     = '0;
          state_next = S_SHF0;
        end else begin
          i_next = i + DW'(1);
        end
      end
      S_SHF0: begin
        sa_ra      = AW'(i);
        state_next = S_SHF1;
      end
      S_SHF1: begin
        if (SW'(sa_rd) >= step) begin
          nxt_we    = 1'b1;
          nxt_wa    = AW'(used);
          nxt_wd    = DW'(SW'(sa_rd) - step);
          used_next = used + DW'(1);
        end
        if (i == len - DW'(1)) begin
          i_next     = '0;
          state_next = S_CLR;
        end else begin
          i_next     = i + DW'(1);
          state_next = S_SHF0;
        end
      end

      // Re-rank: compare (class, class at +step) of neighbors in the new order
      S_RK0: begin
        sa_ra      = '0;
        state_next = S_RK1;
      end
      S_RK1: begin
        prev_next  = sa_rd;
        cur_we     = 1'b1;
        cur_wa     = AW'(sa_rd);
        cur_wd     = '0;
        used_next  = DW'(1);
        i_next     = DW'(1);
        state_next = S_CMP0;
      end
      S_CMP0: begin
        sa_ra      = AW'(i);
        state_next = S_CMP1;
      end
      S_CMP1: begin
        breg_next  = sa_rd;
        nxt_ra     = AW'(sa_rd);
        state_next = S_CMP2;
      end
      S_CMP2: begin
        cb_next    = nxt_rd;
        nxt_ra     = AW'(prev);
        state_next = S_CMP3;
      end
      S_CMP3: begin
        ca_next    = nxt_rd;
        nxt_ra     = AW'(SW'(prev) + step);
        state_next = S_CMP4;
      end
      S_CMP4: begin
        cas_next   = nxt_rd;
        nxt_ra     = AW'(SW'(breg) + step);
        state_next = S_CMP5;
      end
      S_CMP5: begin
        same = (ca == cb) && (SW'(prev) + step < SW'(len)) &&
               (SW'(breg) + step < SW'(len)) && (cas == nxt_rd);
        cur_we    = 1'b1;
        cur_wa    = AW'(breg);
        cur_wd    = same ? used - DW'(1) : used;
        if (!same) used_next = used + DW'(1);
        prev_next = breg;
        if (i == len - DW'(1)) begin
          state_next = S_NEXT;
        end else begin
          i_next     = i + DW'(1);
          state_next = S_CMP0;
        end
      end
      S_NEXT: begin
        classes_next = used;
        step_next    = step2;
        if (used < len && step <= SW'(MAX_LEN)) begin
          used_next  = '0;
          i_next     = (SW'(len) > step2) ? DW'(SW'(len) - step2) : '0;
          state_next = S_TAIL;
        end else begin
          i_next     = '0;
          state_next = S_INV0;
        end
      end

      // Inverse table into the current rank view
      S_INV0: begin
        sa_ra      = AW'(i);
        state_next = S_INV1;
      end
      S_INV1: begin
        cur_we = 1'b1;
        cur_wa = AW'(sa_rd);
        cur_wd = i;
        if (i == len - DW'(1)) begin
          i_next     = '0;
          k_next     = '0;
          state_next = S_KA0;
        end else begin
          i_next     = i + DW'(1);
          state_next = S_INV0;
        end
      end

      // Kasai: carry the match length from one text position to the next
      S_KA0: begin
        cur_ra     = AW'(i);
        state_next = S_KA1;
      end
      S_KA1: begin
        rreg_next = cur_rd;
        kd        = (k != '0) ? k - KW'(1) : '0;
        if (cur_rd == '0) begin
          k_next = '0;
          if (i == DW'(cnt) - DW'(1)) begin
            state_next = S_DONE;
          end else begin
            i_next     = i + DW'(1);
            state_next = S_KA0;
          end
        end else begin
          k_next     = kd;
          sa_ra      = AW'(cur_rd - DW'(1));
          state_next = S_KA2;
        end
      end
      S_KA2: begin
        jreg_next  = sa_rd;
        state_next = S_KA3;
      end
      S_KA3: begin
        if (KW'(i) + k < KW'(cnt) && KW'(jreg) + k < KW'(cnt)) begin
          t_ra       = AW'(KW'(i) + k);
          state_next = S_KA4;
        end else begin
          state_next = S_KA6;
        end
      end
      S_KA4: begin
        t1_next    = t_rd;
        t_ra       = AW'(KW'(jreg) + k);
        state_next = S_KA5;
      end
      S_KA5: begin
        if (t1 == t_rd) begin
          k_next     = k + KW'(1);
          state_next = S_KA3;
        end else begin
          state_next = S_KA6;
        end
      end
      S_KA6: begin
        lc_we = 1'b1;
        lc_wa = AW'(rreg);
        lc_wd = DW'(k);
        if (i == DW'(cnt) - DW'(1)) begin
          state_next = S_DONE;
        end else begin
          i_next     = i + DW'(1);
          state_next = S_KA0;
        end
      end
      S_DONE: begin
        lc_we      = 1'b1;
        lc_wa      = '0;
        lc_wd      = '0;
        built_next = 1'b1;
        state_next = S_Q_RD;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
